// ===== design/fsa_pkg.sv =====
// Shared types and codes for the free segment allocator.
// No dependencies; imported by every module of the block.
package fsa_pkg;

   typedef enum logic [0:0] {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      POL_FIRST = 2'd0,
      POL_BEST  = 2'd1,
      POL_NEXT  = 2'd2
   } policy_type;

   typedef enum logic [1:0] {
      RES_DONE   = 2'd0,
      RES_NO_FIT = 2'd1,
      RES_FULL   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK,
      ST_FETCH,
      ST_TAKE,
      ST_SHIFT,
      ST_WRITE
   } state_type;

   // One table row: segment start and length.
   typedef struct packed {
      logic [31:0] start;
      logic [31:0] size;
   } entry_type;

endpackage

// ===== design/fsa_mem.sv =====
// Segment table storage: one write port, one read port, registered read data.
// Depends on fsa_pkg for the row type.
module fsa_mem
   import fsa_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                             clock,
   input  logic                             rd_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
   output entry_type                        rd_data,
   input  logic                             wr_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
   input  entry_type                        wr_data
);

   entry_type mem [TABLE_ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/fsa_ctrl.sv =====
// Request sequencer: scans the segment table, picks or merges, shifts rows.
// Depends on fsa_pkg; drives the fsa_mem ports.
module fsa_ctrl
   import fsa_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_op,
   input  logic [31:0]                      req_seg_address,
   input  logic [31:0]                      req_seg_length,
   input  logic [1:0]                       policy,
   output logic                             rsp_strobe,
   output logic [1:0]                       rsp_status,
   output logic [31:0]                      rsp_granted_address,
   output logic                             rd_en,
   output logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
   input  entry_type                        rd_data,
   output logic                             wr_en,
   output logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
   output entry_type                        wr_data
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [CW-1:0] ONE = CW'(1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

   state_type state_ff, state_in;
   logic          op_ff, op_in;
   logic [31:0]   addr_ff, addr_in, len_ff, len_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   nfp_ff, nfp_in;
   logic [CW-1:0] idx_ff, idx_in, left_ff, left_in, pend_idx_ff, pend_idx_in;
   logic          pend_ff, pend_in, sh_up_ff, sh_up_in, ins_ff, ins_in;
   logic [CW-1:0] pick_ff, pick_in;
   logic          any_ok_ff, any_ok_in, aft_ok_ff, aft_ok_in, beg_ok_ff, beg_ok_in;
   logic          ex_ok_ff, ex_ok_in, bst_ok_ff, bst_ok_in, found_ff, found_in;
   logic [CW-1:0] any_idx_ff, any_idx_in, aft_idx_ff, aft_idx_in;
   logic [CW-1:0] ex_idx_ff, ex_idx_in, bst_idx_ff, bst_idx_in;
   logic [31:0]   bst_size_ff, bst_size_in;
   entry_type     prv_ff, prv_in, nxt_ff, nxt_in, last_ff, last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [31:0]   rsp_addr_ff, rsp_addr_in;

   // Merge arithmetic, evaluated in the pick cycle.
   entry_type   prev_e;
   logic        has_prev, adj_prev, adj_next, fit, after;
   logic [33:0] prev_end, new_end, sum3, sum_p, sum_n;

   always_comb begin
      prev_e   = found_ff ? prv_ff : last_ff;
      has_prev = (pick_ff != '0);
      prev_end = {2'b00, prev_e.start} + {2'b00, prev_e.size};
      new_end  = {2'b00, addr_ff} + {2'b00, len_ff};
      adj_prev = has_prev && (prev_end == {2'b00, addr_ff});
      adj_next = found_ff && (new_end == {2'b00, nxt_ff.start});
      sum_p    = {2'b00, prev_e.size} + {2'b00, len_ff};
      sum_n    = {2'b00, nxt_ff.size} + {2'b00, len_ff};
      sum3     = sum_p + {2'b00, nxt_ff.size};
      fit      = (rd_data.size >= len_ff);
      after    = beg_ok_ff || (rd_data.start >= nfp_ff);
   end

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      addr_in     = addr_ff;
      len_in      = len_ff;
      count_in    = count_ff;
      nfp_in      = nfp_ff;
      idx_in      = idx_ff;
      left_in     = left_ff;
      pend_in     = pend_ff;
      pend_idx_in = pend_idx_ff;
      sh_up_in    = sh_up_ff;
      ins_in      = ins_ff;
      pick_in     = pick_ff;
      any_ok_in   = any_ok_ff;
      any_idx_in  = any_idx_ff;
      aft_ok_in   = aft_ok_ff;
      aft_idx_in  = aft_idx_ff;
      beg_ok_in   = beg_ok_ff;
      ex_ok_in    = ex_ok_ff;
      ex_idx_in   = ex_idx_ff;
      bst_ok_in   = bst_ok_ff;
      bst_idx_in  = bst_idx_ff;
      bst_size_in = bst_size_ff;
      found_in    = found_ff;
      prv_in      = prv_ff;
      nxt_in      = nxt_ff;
      last_in     = last_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rd_en   = 1'b0;
      rd_addr = idx_ff[IW-1:0];
      wr_en   = 1'b0;
      wr_addr = pick_ff[IW-1:0];
      wr_data = rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in     = req_op;
               addr_in   = req_seg_address;
               len_in    = req_seg_length;
               idx_in    = '0;
               pend_in   = 1'b0;
               any_ok_in = 1'b0;
               aft_ok_in = 1'b0;
               beg_ok_in = 1'b0;
               ex_ok_in  = 1'b0;
               bst_ok_in = 1'b0;
               found_in  = 1'b0;
               pick_in   = '0;
               rsp_addr_in = '0;
               state_in  = ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (idx_ff != count_ff) begin
               rd_en       = 1'b1;
               idx_in      = idx_ff + ONE;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               // Allocate trackers for all three policies in one pass.
               if (fit && !any_ok_ff) begin
                  any_ok_in  = 1'b1;
                  any_idx_in = pend_idx_ff;
               end
               beg_ok_in = after;
               if (fit && after && !aft_ok_ff) begin
                  aft_ok_in  = 1'b1;
                  aft_idx_in = pend_idx_ff;
               end
               if (rd_data.size == len_ff && !ex_ok_ff) begin
                  ex_ok_in  = 1'b1;
                  ex_idx_in = pend_idx_ff;
               end
               if (rd_data.size > len_ff && (!bst_ok_ff || rd_data.size <= bst_size_ff)) begin
                  bst_ok_in   = 1'b1;
                  bst_idx_in  = pend_idx_ff;
                  bst_size_in = rd_data.size;
               end
               // Insert position for a free: first row starting above it.
               if (!found_ff && rd_data.start > addr_ff) begin
                  found_in = 1'b1;
                  pick_in  = pend_idx_ff;
                  prv_in   = last_ff;
                  nxt_in   = rd_data;
               end
               last_in = rd_data;
            end
            if (idx_ff == count_ff && !pend_ff) begin
               if (!found_ff) begin
                  pick_in = count_ff;
               end
               state_in = ST_PICK;
            end
         end

         ST_PICK: begin
            if (op_ff == OP_ALLOC) begin
               case (policy_type'(policy))
                  POL_BEST: begin
                     pick_in = ex_ok_ff ? ex_idx_ff : bst_idx_ff;
                     if (!ex_ok_ff && !bst_ok_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = RES_NO_FIT;
                        state_in      = ST_IDLE;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
                  POL_NEXT: begin
                     pick_in = aft_ok_ff ? aft_idx_ff : any_idx_ff;
                     if (!any_ok_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = RES_NO_FIT;
                        state_in      = ST_IDLE;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                     pick_in = any_idx_ff;
                     if (!any_ok_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = RES_NO_FIT;
                        state_in      = ST_IDLE;
                     end else begin
                        state_in = ST_FETCH;
                     end
                  end
               endcase
            end else if (count_ff == FULL_COUNT) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = RES_FULL;
               state_in      = ST_IDLE;
            end else if (adj_prev && adj_next && sum3[33:32] == 2'b00) begin
               // Three-way merge into the previous row, then drop the next.
               wr_en         = 1'b1;
               wr_addr       = pick_ff[IW-1:0] - IW'(1);
               wr_data.start = prev_e.start;
               wr_data.size  = sum3[31:0];
               count_in      = count_ff - ONE;
               idx_in        = pick_ff + ONE;
               left_in       = count_ff - pick_ff - ONE;
               sh_up_in      = 1'b1;
               ins_in        = 1'b0;
               pend_in       = 1'b0;
               state_in      = ST_SHIFT;
            end else if (adj_prev && sum_p[33:32] == 2'b00) begin
               wr_en         = 1'b1;
               wr_addr       = pick_ff[IW-1:0] - IW'(1);
               wr_data.start = prev_e.start;
               wr_data.size  = sum_p[31:0];
               rsp_valid_in  = 1'b1;
               rsp_status_in = RES_DONE;
               state_in      = ST_IDLE;
            end else if (adj_next && sum_n[33:32] == 2'b00) begin
               wr_en         = 1'b1;
               wr_data.start = addr_ff;
               wr_data.size  = sum_n[31:0];
               rsp_valid_in  = 1'b1;
               rsp_status_in = RES_DONE;
               state_in      = ST_IDLE;
            end else begin
               // Open a gap at the insert position, top row first.
               idx_in   = count_ff - ONE;
               left_in  = count_ff - pick_ff;
               sh_up_in = 1'b0;
               ins_in   = 1'b1;
               pend_in  = 1'b0;
               state_in = ST_SHIFT;
            end
         end

         ST_FETCH: begin
            rd_en    = 1'b1;
            rd_addr  = pick_ff[IW-1:0];
            state_in = ST_TAKE;
         end

         ST_TAKE: begin
            rsp_addr_in = rd_data.start;
            if (policy_type'(policy) == POL_NEXT) begin
               nfp_in = rd_data.start + len_ff;
            end
            if (rd_data.size == len_ff) begin
               count_in = count_ff - ONE;
               idx_in   = pick_ff + ONE;
               left_in  = count_ff - pick_ff - ONE;
               sh_up_in = 1'b1;
               ins_in   = 1'b0;
               pend_in  = 1'b0;
               state_in = ST_SHIFT;
            end else begin
               wr_en         = 1'b1;
               wr_data.start = rd_data.start + len_ff;
               wr_data.size  = rd_data.size - len_ff;
               rsp_valid_in  = 1'b1;
               rsp_status_in = RES_DONE;
               state_in      = ST_IDLE;
            end
         end

         ST_SHIFT: begin
            if (left_ff != '0) begin
               rd_en       = 1'b1;
               idx_in      = sh_up_ff ? idx_ff + ONE : idx_ff - ONE;
               left_in     = left_ff - ONE;
               pend_in     = 1'b1;
               pend_idx_in = idx_ff;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = sh_up_ff ? pend_idx_ff[IW-1:0] - IW'(1)
                                  : pend_idx_ff[IW-1:0] + IW'(1);
               wr_data = rd_data;
            end
            if (left_ff == '0 && !pend_ff) begin
               if (ins_ff) begin
                  state_in = ST_WRITE;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = RES_DONE;
                  state_in      = ST_IDLE;
               end
            end
         end

         ST_WRITE: begin
            wr_en         = 1'b1;
            wr_data.start = addr_ff;
            wr_data.size  = len_ff;
            count_in      = count_ff + ONE;
            rsp_valid_in  = 1'b1;
            rsp_status_in = RES_DONE;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         nfp_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         nfp_ff       <= nfp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      idx_ff        <= idx_in;
      left_ff       <= left_in;
      pend_ff       <= pend_in;
      pend_idx_ff   <= pend_idx_in;
      sh_up_ff      <= sh_up_in;
      ins_ff        <= ins_in;
      pick_ff       <= pick_in;
      any_ok_ff     <= any_ok_in;
      any_idx_ff    <= any_idx_in;
      aft_ok_ff     <= aft_ok_in;
      aft_idx_ff    <= aft_idx_in;
      beg_ok_ff     <= beg_ok_in;
      ex_ok_ff      <= ex_ok_in;
      ex_idx_ff     <= ex_idx_in;
      bst_ok_ff     <= bst_ok_in;
      bst_idx_ff    <= bst_idx_in;
      bst_size_ff   <= bst_size_in;
      found_ff      <= found_in;
      prv_ff        <= prv_in;
      nxt_ff        <= nxt_in;
      last_ff       <= last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_strobe          = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_address = rsp_addr_ff;

endmodule

// ===== design/free_segment_allocator.sv =====
// Top level of the free segment allocator: policy register and block wiring.
// Depends on fsa_pkg, fsa_mem and fsa_ctrl.
//
// Usage. An item (req_op, req_seg_address, req_seg_length) is taken at a rising
// edge where start is high and busy is low. req_op selects allocate or free.
// Exactly one result per item appears on rsp_status and rsp_granted_address for
// a single cycle, marked by rsp_strobe; the receiver must take it then, as the
// block has no way to hold it. busy drops in the same cycle the strobe rises,
// so the next item may be started while the result is shown.
//
// Operation. Every item first scans the occupied table rows, one row per cycle
// through the single read port of the table memory. An allocate that empties a
// row, a three-way merge and a plain insert also move the rows above the
// affected position by one, one row per cycle; a plain insert then writes the
// new row into the gap.
//
// The placement policy is written through the csr_ channel while the block is
// idle; csr_ready is low while an item is in progress. Reset empties the
// table logically (row count zero, no clearing pass), selects first fit and
// rewinds the next-fit pointer.
module free_segment_allocator
   import fsa_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [31:0] req_seg_address,
   input  logic [31:0] req_seg_length,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_granted_address,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_fit_policy
);

   localparam int IW = $clog2(TABLE_ENTRIES);

   // Placement policy; an unused code behaves as first fit.
   logic [1:0] policy_ff;

   logic            rd_en, wr_en;
   logic [IW-1:0]   rd_addr, wr_addr;
   entry_type       rd_data, wr_data;

   assign csr_ready = !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= POL_FIRST;
      end else if (csr_valid && csr_ready) begin
         policy_ff <= csr_fit_policy;
      end
   end

   fsa_mem #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   fsa_ctrl #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_op              (req_op),
      .req_seg_address     (req_seg_address),
      .req_seg_length      (req_seg_length),
      .policy              (policy_ff),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address),
      .rd_en               (rd_en),
      .rd_addr             (rd_addr),
      .rd_data             (rd_data),
      .wr_en               (wr_en),
      .wr_addr             (wr_addr),
      .wr_data             (wr_data)
   );

endmodule

// ===== design/fsa_checker.sv =====
// Port-level checks for the free segment allocator, bound to its top level.
// Depends on fsa_pkg for the result codes.
module fsa_checker
   import fsa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_granted_address
);

   // An accepted item always makes the block busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // A result closes its item, so the block is idle while showing it.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while busy");

   // Every item passes through the scan and pick states, so results never come back to back.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // Failed requests never carry a grant.
   a_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != RES_DONE |-> rsp_granted_address == '0)
      else $error("grant address on a failed request");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == RES_DONE || rsp_status == RES_NO_FIT ||
                      rsp_status == RES_FULL))
      else $error("undefined result status");

endmodule

bind free_segment_allocator fsa_checker u_fsa_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_strobe          (rsp_strobe),
   .rsp_status          (rsp_status),
   .rsp_granted_address (rsp_granted_address)
);
